// File: hdl/jke_pkg.sv
// Shared constants and types for the Josephus key elimination block.
`default_nettype none

package jke_pkg;

    localparam int MAX_PARTICIPANTS = 64;
    localparam int PTR_W  = (MAX_PARTICIPANTS > 1) ? $clog2(MAX_PARTICIPANTS) : 1;
    localparam int CNT_W  = $clog2(MAX_PARTICIPANTS + 1);
    localparam int KEY_W  = 16;
    localparam int POS_W  = 7;
    localparam int ITER_W = $clog2(KEY_W + 1);

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_START = 1'b1;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [PTR_W-1:0] rem;
    } t_mod_rsp;

endpackage

`default_nettype wire

// File: hdl/jke_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module jke_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/jke_mod.sv
// Bit-serial remainder unit: count modulo the live ring size, one bit a cycle.
`default_nettype none

module jke_mod
    import jke_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mod_req i_req,
    output t_mod_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_iter;
    logic [KEY_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_div;
    logic [PTR_W-1:0]  r_rem;

    logic [CNT_W:0]   sh_x;
    logic [CNT_W:0]   d_x;
    logic [CNT_W:0]   diff;
    logic [PTR_W-1:0] n_rem;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        sh_x  = (CNT_W+1)'({r_rem, r_quo[KEY_W-1]});
        d_x   = (CNT_W+1)'(r_div);
        diff  = sh_x - d_x;
        n_rem = (sh_x >= d_x) ? diff[PTR_W-1:0] : sh_x[PTR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_iter <= ITER_W'(KEY_W);
                r_quo  <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quo  <= {r_quo[KEY_W-2:0], 1'b0};
                r_iter <= r_iter - 1'b1;
                if (r_iter == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

// File: hdl/josephus_key_elimination.sv
// A load transaction writes one entry; a start emits one result per removal.
// Each removal runs the remainder unit, then one ring step per remaining count
// (at most live - 1 steps) and then the removal itself, held while a result waits at the output.
// While a start is in progress, input is held off.
// Synchronous active-low reset clears control, fill count and output valid; the key
// and link memories are not cleared and need no clearing pass.
`default_nettype none

module josephus_key_elimination
    import jke_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,  // [15:0] entry_key, [31:16] initial_count
    input  wire logic        i_s_tuser,  // [0] req_type
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [7:0]  o_m_tdata,  // [6:0] position, [7] zero
    output logic             o_m_tlast,  // is_last
    output logic             o_m_tuser   // [0] empty_error
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIV,
        ST_WALK
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_loaded;
    logic [CNT_W-1:0] r_live;
    logic [PTR_W-1:0] r_cur;
    logic [PTR_W-1:0] r_prev;
    logic [PTR_W-1:0] r_steps;
    t_mod_req         r_mod_req;
    logic             r_out_valid;
    logic [POS_W-1:0] r_out_pos;
    logic             r_out_last;
    logic             r_out_err;

    t_mod_rsp         mod_rsp;
    logic [KEY_W-1:0] key_q;
    logic [PTR_W-1:0] nxt_q;
    logic             s_acc;
    logic             load_wr;
    logic             close_wr;
    logic             slot_free;
    logic             step;
    logic             remove;
    logic [PTR_W-1:0] load_idx;
    logic [PTR_W-1:0] last_idx;
    logic [PTR_W-1:0] rd_addr;
    logic             nxt_we;
    logic [PTR_W-1:0] nxt_waddr;
    logic [PTR_W-1:0] nxt_wdata;
    logic [KEY_W-1:0] cnt_src;
    logic [KEY_W-1:0] div_in;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign load_wr    = s_acc && (i_s_tuser == REQ_LOAD)
                        && (r_loaded < CNT_W'(MAX_PARTICIPANTS));
    assign close_wr   = s_acc && (i_s_tuser == REQ_START) && (r_loaded != '0);
    assign slot_free  = !r_out_valid || i_m_tready;
    assign step       = (r_state == ST_WALK) && (r_steps != '0);
    assign remove     = (r_state == ST_WALK) && (r_steps == '0) && slot_free;
    assign load_idx   = r_loaded[PTR_W-1:0];
    assign last_idx   = PTR_W'(r_loaded - 1'b1);

    // follow the link at once while stepping, else keep reading the current node
    assign rd_addr = step ? nxt_q : r_cur;

    always_comb begin
        nxt_we = load_wr || close_wr || remove;
        if (remove) begin
            nxt_waddr = r_prev;
            nxt_wdata = nxt_q;
        end else if (close_wr) begin
            nxt_waddr = last_idx;
            nxt_wdata = '0;
        end else begin
            nxt_waddr = load_idx;
            nxt_wdata = load_idx + 1'b1;
        end
    end

    // a zero count acts as one, so the dividend is count - 1 (walk length is that modulo live size)
    assign cnt_src = (r_state == ST_IDLE) ? i_s_tdata[31:16] : key_q;
    assign div_in  = (cnt_src == '0) ? '0 : cnt_src - 1'b1;

    jke_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_PARTICIPANTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (load_wr),
        .i_waddr (load_idx),
        .i_wdata (i_s_tdata[15:0]),
        .i_raddr (rd_addr),
        .o_rdata (key_q)
    );

    jke_ram #(
        .WIDTH (PTR_W),
        .DEPTH (MAX_PARTICIPANTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_waddr),
        .i_wdata (nxt_wdata),
        .i_raddr (rd_addr),
        .o_rdata (nxt_q)
    );

    jke_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mod_req),
        .o_rsp   (mod_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_loaded        <= '0;
            r_live          <= '0;
            r_steps         <= '0;
            r_mod_req.start <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_mod_req.start <= 1'b0;
            if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (load_wr) begin
                        r_loaded <= r_loaded + 1'b1;
                    end
                    if (close_wr) begin
                        r_live             <= r_loaded;
                        r_cur              <= '0;
                        r_prev             <= last_idx;
                        r_mod_req.start    <= 1'b1;
                        r_mod_req.dividend <= div_in;
                        r_mod_req.divisor  <= r_loaded;
                        r_state            <= ST_DIV;
                    end else if (s_acc && (i_s_tuser == REQ_START)) begin
                        r_state <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_pos   <= '0;
                        r_out_last  <= 1'b1;
                        r_out_err   <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    if (mod_rsp.done) begin
                        r_steps <= mod_rsp.rem;
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (step) begin
                        r_prev  <= r_cur;
                        r_cur   <= nxt_q;
                        r_steps <= r_steps - 1'b1;
                    end else if (remove) begin
                        // unlink the current node and emit its position
                        r_out_valid <= 1'b1;
                        r_out_pos   <= POS_W'(r_cur) + 1'b1;
                        r_out_last  <= (r_live == CNT_W'(1));
                        r_out_err   <= 1'b0;
                        r_live      <= r_live - 1'b1;
                        r_cur       <= nxt_q;
                        if (r_live == CNT_W'(1)) begin
                            r_loaded <= '0;
                            r_state  <= ST_IDLE;
                        end else begin
                            r_mod_req.start    <= 1'b1;
                            r_mod_req.dividend <= div_in;
                            r_mod_req.divisor  <= r_live - 1'b1;
                            r_state            <= ST_DIV;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_pos};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_err;

    a_steps_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (CNT_W'(r_steps) < r_live))
        else $error("walk length not below live ring size");

    a_last_clears_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (remove && (r_live == CNT_W'(1))) |=> (r_state == ST_IDLE && r_loaded == '0))
        else $error("final removal did not empty the ring");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_rsp.done |-> (r_state == ST_DIV))
        else $error("remainder done outside divide state");

    a_live_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_live <= CNT_W'(MAX_PARTICIPANTS)) && (r_loaded <= CNT_W'(MAX_PARTICIPANTS)))
        else $error("ring count above capacity");

endmodule

`default_nettype wire
